FILE: hw/rtl/alpha_over_pixel_blend_unit_assert.svh
// Assertion macros for the alpha-over pixel blend unit.
`ifndef ALPHA_OVER_PIXEL_BLEND_UNIT_ASSERT_SVH
`define ALPHA_OVER_PIXEL_BLEND_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AOPB_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blend unit assertion failed");
`define AOPB_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blend unit assertion failed");
`else
`define AOPB_ASSERT_IMP(name, clk, rst, ante, cons)
`define AOPB_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/aopb_pkg.sv
// Shared constants, types and helpers of the alpha-over pixel blend unit.
`timescale 1ns / 1ps
`default_nettype none
package aopb_pkg;

  localparam logic [7:0]  FULL_ALPHA  = 8'd255;
  localparam logic [7:0]  HALF_ROUND  = 8'd127;
  localparam logic [31:0] RECIP_255   = 32'h0000_8081;
  localparam int          RECIP_SHIFT = 23;

  localparam int NUM_W      = 25;
  localparam int DEN_W      = 16;
  localparam int Q_W        = 8;
  localparam int STEPS      = 2;
  localparam int DIV_STAGES = Q_W / STEPS;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LAYER_OPACITY    = 2'd0,
    REG_KEEP_ALPHA       = 2'd1,
    REG_SOURCE_HAS_ALPHA = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [2:0][7:0] src;
    logic [2:0][7:0] dst;
    logic [2:0][7:0] mixo;
    logic [7:0]      sa;
    logic [7:0]      da;
    logic [7:0]      oa;
    logic [2:0]      sat;
  } fin_t;

  // exact floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * RECIP_255;
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aopb_div.sv
// Pipelined restoring divider giving an 8-bit quotient, two bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module aopb_div
  import aopb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] n,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   q
);

  logic [NUM_W-1:0] rem_r [DIV_STAGES-1];
  logic [DEN_W-1:0] den_r [DIV_STAGES-1];
  logic [Q_W-1:0]   q_r   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] rem_o;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [Q_W-1:0]   q_o;

    if (g == 0) begin : g_first
      assign rem_in = n;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign q_in   = q_r[g-1];
    end

    always_comb begin
      logic [NUM_W:0]   trial;
      logic [NUM_W-1:0] sub;
      rem_o = rem_in;
      q_o   = q_in;
      for (int j = 0; j < STEPS; j++) begin
        sub   = NUM_W'(den_in) << (Q_W - 1 - (g * STEPS + j));
        trial = {1'b0, rem_o} - {1'b0, sub};
        if (!trial[NUM_W]) begin
          rem_o = trial[NUM_W-1:0];
          q_o[Q_W - 1 - (g * STEPS + j)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      q_r[g] <= q_o;
    end

    if (g < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[g] <= rem_o;
        den_r[g] <= den_in;
      end
    end
  end

  assign q = q_r[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/alpha_over_pixel_blend_unit.sv
// Top level of the alpha-over pixel blend unit.
// Blends one straight-alpha source pixel over one destination pixel per clock.
// Start is taken in any cycle in which busy is low; busy is high only during
// reset. Each result appears on the out_* ports with done high for exactly one
// cycle, in the order of the starts; the receiver cannot stall the unit. Each
// result passes through five arithmetic stages (opacity scale, reciprocal
// divide by 255, products, reciprocal divides and numerators, divisor setup),
// four divider stages that resolve two quotient bits each, and the output
// register. Write configuration only while no pixel is in flight;
// cfg_ready is high outside reset.
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_over_pixel_blend_unit_assert.svh"
module alpha_over_pixel_blend_unit
  import aopb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [7:0]           src_red,
  input  wire logic [7:0]           src_green,
  input  wire logic [7:0]           src_blue,
  input  wire logic [7:0]           src_alpha,
  input  wire logic [7:0]           dst_red,
  input  wire logic [7:0]           dst_green,
  input  wire logic [7:0]           dst_blue,
  input  wire logic [7:0]           dst_alpha,
  output logic                      done,
  output logic      [7:0]           out_red,
  output logic      [7:0]           out_green,
  output logic      [7:0]           out_blue,
  output logic      [7:0]           out_alpha,
  output logic                      changed,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int NSTAGE = 6 + DIV_STAGES;

  logic [7:0] layer_opacity;
  logic       keep_alpha;
  logic       source_has_alpha;

  logic              accept;
  logic [NSTAGE-1:0] vld;
  logic [2:0][7:0]   in_src;
  logic [2:0][7:0]   in_dst;
  logic [7:0]        sa_raw;

  logic [15:0]     s1_psa;
  logic [2:0][7:0] s1_src;
  logic [2:0][7:0] s1_dst;
  logic [7:0]      s1_da;

  logic [7:0]      s2_sa;
  logic [2:0][7:0] s2_src;
  logic [2:0][7:0] s2_dst;
  logic [7:0]      s2_da;
  logic [7:0]      s2_isa;

  logic [2:0][15:0] s3_ssa;
  logic [2:0][15:0] s3_dda;
  logic [2:0][15:0] s3_mx;
  logic [15:0]      s3_oax;
  logic [7:0]       s3_sa;
  logic [7:0]       s3_isa;
  logic [7:0]       s3_da;
  logic [2:0][7:0]  s3_src;
  logic [2:0][7:0]  s3_dst;

  logic [2:0][7:0]       s4_mixo;
  logic [7:0]            s4_oa;
  logic [2:0][NUM_W-1:0] s4_num;
  logic [7:0]            s4_sa;
  logic [7:0]            s4_da;
  logic [2:0][7:0]       s4_src;
  logic [2:0][7:0]       s4_dst;

  logic [DEN_W-1:0]      den_next;
  logic [2:0][NUM_W-1:0] n_next;
  logic [2:0]            sat_next;
  logic [2:0][NUM_W-1:0] s5_n;
  logic [DEN_W-1:0]      s5_den;
  fin_t                  s5_fin;

  fin_t            fin_d [DIV_STAGES];
  fin_t            fin;
  logic [2:0][7:0] div_q;

  logic [2:0][7:0] rgb_next;
  logic [7:0]      alpha_next;
  logic            changed_next;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_opacity    <= FULL_ALPHA;
      keep_alpha       <= 1'b0;
      source_has_alpha <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYER_OPACITY:    layer_opacity    <= cfg_data;
        REG_KEEP_ALPHA:       keep_alpha       <= cfg_data[0];
        REG_SOURCE_HAS_ALPHA: source_has_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], accept};
    end
  end

  assign in_src = {src_blue, src_green, src_red};
  assign in_dst = {dst_blue, dst_green, dst_red};
  assign sa_raw = source_has_alpha ? src_alpha : FULL_ALPHA;

  always_ff @(posedge clk) begin
    s1_psa <= 16'(sa_raw) * 16'(layer_opacity) + 16'(HALF_ROUND);
    s1_src <= in_src;
    s1_dst <= in_dst;
    s1_da  <= dst_alpha;
  end

  always_ff @(posedge clk) begin
    s2_sa  <= div255(s1_psa);
    s2_src <= s1_src;
    s2_dst <= s1_dst;
    s2_da  <= s1_da;
  end

  assign s2_isa = FULL_ALPHA - s2_sa;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s3_ssa[c] <= 16'(s2_src[c]) * 16'(s2_sa);
      s3_dda[c] <= 16'(s2_dst[c]) * 16'(s2_da);
      s3_mx[c]  <= 16'(s2_src[c]) * 16'(s2_sa) + 16'(s2_dst[c]) * 16'(s2_isa)
                   + 16'(HALF_ROUND);
    end
    s3_oax <= ({s2_sa, 8'b0} - 16'(s2_sa)) + 16'(s2_da) * 16'(s2_isa) + 16'(HALF_ROUND);
    s3_sa  <= s2_sa;
    s3_isa <= s2_isa;
    s3_da  <= s2_da;
    s3_src <= s2_src;
    s3_dst <= s2_dst;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s4_mixo[c] <= div255(s3_mx[c]);
      s4_num[c]  <= NUM_W'({s3_ssa[c], 8'b0} - 24'(s3_ssa[c]))
                    + NUM_W'(24'(s3_dda[c]) * 24'(s3_isa));
    end
    s4_oa  <= div255(s3_oax);
    s4_sa  <= s3_sa;
    s4_da  <= s3_da;
    s4_src <= s3_src;
    s4_dst <= s3_dst;
  end

  always_comb begin
    den_next = {s4_oa, 8'b0} - DEN_W'(s4_oa);
    for (int c = 0; c < 3; c++) begin
      n_next[c]   = s4_num[c] + NUM_W'(den_next >> 1);
      sat_next[c] = n_next[c] >= NUM_W'({den_next, 8'b0});
    end
  end

  always_ff @(posedge clk) begin
    s5_n        <= n_next;
    s5_den      <= den_next;
    s5_fin.src  <= s4_src;
    s5_fin.dst  <= s4_dst;
    s5_fin.mixo <= s4_mixo;
    s5_fin.sa   <= s4_sa;
    s5_fin.da   <= s4_da;
    s5_fin.oa   <= s4_oa;
    s5_fin.sat  <= sat_next;
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    aopb_div u_div (
      .clk (clk),
      .n   (s5_n[c]),
      .den (s5_den),
      .q   (div_q[c])
    );
  end

  always_ff @(posedge clk) begin
    fin_d[0] <= s5_fin;
    for (int i = 1; i < DIV_STAGES; i++) begin
      fin_d[i] <= fin_d[i-1];
    end
  end

  assign fin = fin_d[DIV_STAGES-1];

  always_comb begin
    rgb_next     = fin.dst;
    alpha_next   = fin.da;
    changed_next = 1'b0;
    if (fin.sa != '0) begin
      if (!keep_alpha) begin
        changed_next = 1'b1;
        rgb_next     = (fin.sa == FULL_ALPHA) ? fin.src : fin.mixo;
      end else if (fin.sa == FULL_ALPHA) begin
        changed_next = 1'b1;
        rgb_next     = fin.src;
        alpha_next   = FULL_ALPHA;
      end else if (fin.da == '0) begin
        changed_next = 1'b1;
        rgb_next     = fin.src;
        alpha_next   = fin.sa;
      end else if (fin.oa != '0) begin
        changed_next = 1'b1;
        alpha_next   = fin.oa;
        for (int c = 0; c < 3; c++) begin
          rgb_next[c] = fin.sat[c] ? FULL_ALPHA : div_q[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= rgb_next[0];
    out_green <= rgb_next[1];
    out_blue  <= rgb_next[2];
    out_alpha <= alpha_next;
    changed   <= changed_next;
  end

  assign done = vld[NSTAGE-1];

  `AOPB_ASSERT_IMP(a_done_latency, clk, rst, done, $past(accept, NSTAGE))
  `AOPB_ASSERT_NXT(a_skip_keeps_dst, clk, rst, vld[NSTAGE-2] && fin.sa == '0, !changed && out_alpha == $past(fin.da))
  `AOPB_ASSERT_NXT(a_full_copies_src, clk, rst, vld[NSTAGE-2] && fin.sa == FULL_ALPHA, changed && out_red == $past(fin.src[0]))

endmodule
`default_nettype wire
